FILE: hdl/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg
// Shared types, character codes and the scanner transition table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ats_pkg;

  localparam int TOKEN_W           = 16;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [TOKEN_W-1:0] TALLY_MAX = '1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_R     = 8'h72;

  typedef enum logic [3:0] {
    ST_START   = 4'd0,
    ST_IMM     = 4'd1,
    ST_REG     = 4'd2,
    ST_ID      = 4'd3,
    ST_LABEL   = 4'd4,
    ST_NEWLINE = 4'd5,
    ST_ERROR   = 4'd6,
    ST_COMMENT = 4'd7,
    ST_IMMCHK  = 4'd8,
    ST_REGCHK  = 4'd9
  } scan_state_e;

  typedef enum logic [2:0] {
    KIND_REG   = 3'd0,
    KIND_IMM   = 3'd1,
    KIND_ID    = 3'd2,
    KIND_LABEL = 3'd3,
    KIND_ERR   = 3'd4,
    KIND_NL    = 3'd5
  } token_kind_e;

  typedef struct packed {
    logic               has_word;
    logic               has_nl;
    token_kind_e        word_kind;
    logic [TOKEN_W-1:0] word_start;
    logic [TOKEN_W-1:0] word_len;
    logic [TOKEN_W-1:0] nl_start;
    logic [TOKEN_W-1:0] tally;
  } token_event_t;

  function automatic scan_state_e next_state(scan_state_e s, logic is_digit);
    scan_state_e n;
    case (s)
      ST_START:   n = is_digit ? ST_IMM : ST_ID;
      ST_IMM:     n = ST_IMM;
      ST_REG:     n = ST_ID;
      ST_ID:      n = ST_ID;
      ST_LABEL:   n = ST_ERROR;
      ST_NEWLINE: n = ST_START;
      ST_ERROR:   n = ST_ERROR;
      ST_COMMENT: n = ST_COMMENT;
      ST_IMMCHK:  n = ST_IMM;
      ST_REGCHK:  n = is_digit ? ST_REG : ST_ID;
      default:    n = ST_ERROR;
    endcase
    return n;
  endfunction

  function automatic logic [TOKEN_W-1:0] sat_inc(logic [TOKEN_W-1:0] v);
    return (v == TALLY_MAX) ? v : v + TOKEN_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/assembly_token_scanner.sv
// ----------------------------------------------------------------------------
// assembly_token_scanner
// Scans assembly source one character per word and emits tokens.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i / in_stall_o  char_code_i
// out      output     out_valid_o / out_stall_i token_kind_o, token_start_o,
//                                              token_length_o, error_total_o,
//                                              last_of_run_o
//
// One character is taken per cycle unless the input is stalled; the scanner
// state register in the front closes the state loop. A character gives zero,
// one or two tokens; the back sends one token per cycle unless the output is
// stalled, so a word cut by a newline gives a word token, then a newline
// token. Reset clears the scanner, queue and output register. An out stall
// fills the event queue and then stalls the input; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module assembly_token_scanner #(
  parameter int POSITION_BITS = ats_pkg::POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = ats_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [7:0]                char_code_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [2:0]                     token_kind_o,
  output logic [ats_pkg::TOKEN_W-1:0]    token_start_o,
  output logic [ats_pkg::TOKEN_W-1:0]    token_length_o,
  output logic [ats_pkg::TOKEN_W-1:0]    error_total_o,
  output logic                           last_of_run_o
);
  import ats_pkg::*;

  token_event_t push_ev, head_ev;
  logic         push, pop, full, empty;

  ats_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .full_i      (full),
    .push_o      (push),
    .event_o     (push_ev)
  );

  ats_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_ev),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_ev),
    .empty_o (empty)
  );

  ats_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .event_i        (head_ev),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .error_total_o  (error_total_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

`default_nettype wire

FILE: hdl/ats_front.sv
// ----------------------------------------------------------------------------
// ats_front
// Accepts characters, steps the scanner and posts token events to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_front #(
  parameter int POSITION_BITS = ats_pkg::POSITION_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           char_code_i,
  input  wire logic                 full_i,
  output logic                      push_o,
  output ats_pkg::token_event_t     event_o
);
  import ats_pkg::*;

  scan_state_e              scan_q, scan_d, prior_q, prior_d, go_st, s1, p1;
  logic [POSITION_BITS-1:0] pos_q, pos_d, wb_q, wb_d, len_raw;
  logic [TOKEN_W-1:0]       tally_q, tally_d, tally_bad;
  logic                     accept, in_comment, do_go, bad_char, emit, has_word, has_nl;
  logic                     is_alpha, is_digit;
  token_kind_e              kind;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    in_comment = (scan_q == ST_COMMENT);
    is_alpha   = ((char_code_i >= 8'h61) && (char_code_i <= 8'h7a)) ||
                 ((char_code_i >= 8'h41) && (char_code_i <= 8'h5a));
    is_digit   = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
    do_go      = 1'b0;
    go_st      = ST_START;
    bad_char   = 1'b0;

    if (char_code_i == CH_TAB || char_code_i == CH_SPACE) begin
      do_go = !in_comment;
      go_st = ST_START;
    end else if (char_code_i == CH_R) begin
      do_go = 1'b1;
      go_st = (scan_q == ST_START) ? ST_REGCHK : next_state(scan_q, 1'b0);
    end else if (char_code_i == CH_MINUS) begin
      do_go = (scan_q == ST_START) || !in_comment;
      go_st = (scan_q == ST_START) ? ST_IMMCHK : ST_ERROR;
    end else if (char_code_i == CH_COLON) begin
      do_go = (scan_q == ST_ID) || !in_comment;
      go_st = (scan_q == ST_ID) ? ST_LABEL : ST_ERROR;
    end else if (char_code_i == CH_NL) begin
      do_go = 1'b1;
      go_st = ST_NEWLINE;
    end else if (char_code_i == CH_HASH) begin
      do_go = 1'b1;
      go_st = ST_COMMENT;
    end else if (is_alpha || is_digit) begin
      do_go = 1'b1;
      go_st = next_state(scan_q, is_digit);
    end else if (!in_comment) begin
      do_go    = 1'b1;
      go_st    = ST_ERROR;
      bad_char = 1'b1;
    end

    s1       = do_go ? go_st : scan_q;
    p1       = do_go ? scan_q : prior_q;
    emit     = (s1 == ST_START) || (s1 == ST_NEWLINE);
    has_nl   = (s1 == ST_NEWLINE);
    has_word = emit && (p1 != ST_START) && (p1 != ST_NEWLINE) && (p1 != ST_COMMENT);
    len_raw  = pos_q - wb_q;

    case (p1)
      ST_REG:    kind = KIND_REG;
      ST_IMM:    kind = KIND_IMM;
      ST_ID:     kind = KIND_ID;
      ST_REGCHK: kind = KIND_ID;
      ST_LABEL:  kind = KIND_LABEL;
      default:   kind = KIND_ERR;
    endcase
    if (kind == KIND_LABEL) begin
      len_raw = len_raw - POSITION_BITS'(1);
    end

    tally_bad = bad_char ? sat_inc(tally_q) : tally_q;
    tally_d   = (has_word && kind == KIND_ERR) ? sat_inc(tally_bad) : tally_bad;
    pos_d     = pos_q + POSITION_BITS'(1);

    if (emit) begin
      scan_d  = ST_START;
      prior_d = s1;
      wb_d    = pos_d;
    end else begin
      scan_d  = s1;
      prior_d = p1;
      wb_d    = (p1 == ST_START) ? pos_q : wb_q;
    end

    event_o.has_word   = has_word;
    event_o.has_nl     = has_nl;
    event_o.word_kind  = kind;
    event_o.word_start = TOKEN_W'(wb_q);
    event_o.word_len   = TOKEN_W'(len_raw);
    event_o.nl_start   = TOKEN_W'(pos_q);
    event_o.tally      = tally_d;
    push_o = accept && (char_code_i != CH_NUL) && (has_word || has_nl);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= ST_START;
      prior_q <= ST_START;
      pos_q   <= '0;
      wb_q    <= '0;
      tally_q <= '0;
    end else if (accept) begin
      if (char_code_i == CH_NUL) begin
        scan_q  <= ST_START;
        prior_q <= ST_START;
        pos_q   <= '0;
        wb_q    <= '0;
        tally_q <= '0;
      end else begin
        scan_q  <= scan_d;
        prior_q <= prior_d;
        pos_q   <= pos_d;
        wb_q    <= wb_d;
        tally_q <= tally_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ats_queue.sv
// ----------------------------------------------------------------------------
// ats_queue
// Short first-in first-out queue of token events between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_queue #(
  parameter int DEPTH = ats_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire ats_pkg::token_event_t data_i,
  output logic                       full_o,
  input  wire logic                  pop_i,
  output ats_pkg::token_event_t      data_o,
  output logic                       empty_o
);
  import ats_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  token_event_t  mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    rd_d  = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    cnt_d = cnt_q + CW'(push_i) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_d;
      end
      if (pop_i) begin
        rd_q <= rd_d;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ats_back.sv
// ----------------------------------------------------------------------------
// ats_back
// Unpacks queued events into tokens, word token before newline token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ats_pkg::token_event_t     event_i,
  input  wire logic                      empty_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [2:0]                     token_kind_o,
  output logic [ats_pkg::TOKEN_W-1:0]    token_start_o,
  output logic [ats_pkg::TOKEN_W-1:0]    token_length_o,
  output logic [ats_pkg::TOKEN_W-1:0]    error_total_o,
  output logic                           last_of_run_o
);
  import ats_pkg::*;

  logic               vld_q, vld_d, phase_q, phase_d, load, take, word_first;
  token_kind_e        kind_d;
  logic [TOKEN_W-1:0] start_d, len_d;
  logic               last_d;
  token_kind_e        kind_q;
  logic [TOKEN_W-1:0] start_q, len_q, total_q;
  logic               last_q;

  always_comb begin
    load       = !vld_q || !out_stall_i;
    take       = load && !empty_i;
    word_first = event_i.has_word && !phase_q;
    if (word_first) begin
      kind_d  = event_i.word_kind;
      start_d = event_i.word_start;
      len_d   = event_i.word_len;
      last_d  = !event_i.has_nl;
      phase_d = take ? event_i.has_nl : phase_q;
      pop_o   = take && !event_i.has_nl;
    end else begin
      kind_d  = KIND_NL;
      start_d = event_i.nl_start;
      len_d   = TOKEN_W'(1);
      last_d  = 1'b1;
      phase_d = take ? 1'b0 : phase_q;
      pop_o   = take;
    end
    vld_d = take ? 1'b1 : (load ? 1'b0 : vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      vld_q   <= vld_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      kind_q  <= kind_d;
      start_q <= start_d;
      len_q   <= len_d;
      total_q <= event_i.tally;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = vld_q;
  assign token_kind_o   = kind_q;
  assign token_start_o  = start_q;
  assign token_length_o = len_q;
  assign error_total_o  = total_q;
  assign last_of_run_o  = last_q;

endmodule

`default_nettype wire

FILE: hdl/ats_checker.sv
// ----------------------------------------------------------------------------
// ats_checker
// Port-level checks on the token output of the scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ats_checker (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic [2:0]             token_kind_o,
  input wire logic [ats_pkg::TOKEN_W-1:0] token_length_o,
  input wire logic                   last_of_run_o
);
  import ats_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o)
      && $stable(token_length_o) && $stable(last_of_run_o))
    else $error("token changed while stalled");

  a_nl_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_NL |-> token_length_o == TOKEN_W'(1))
    else $error("newline token length not one");

  a_nl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_NL |-> last_of_run_o)
    else $error("newline token not last of run");

  a_word_then_nl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> token_kind_o != KIND_NL)
    else $error("non-final token is a newline");

endmodule

bind assembly_token_scanner ats_checker u_ats_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_assembly_token_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_assembly_token_scanner
// Feeds assembly text to the token scanner one character per word and checks
// every token against a cycle-free predictor of the ten-state scanner. Covers
// each token kind, comments, zero-byte clears and a long bad word, then random
// well-formed lines mixed with noise, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_assembly_token_scanner;
  import ats_pkg::*;

  localparam int POS_W     = POSITION_BITS_DEF;
  localparam int CYCLE_CAP = 2_000_000;
  localparam int IDLE_PCT  = 27;

  typedef struct packed {
    token_kind_e        kind;
    logic [TOKEN_W-1:0] first;
    logic [TOKEN_W-1:0] span;
    logic [TOKEN_W-1:0] tally;
    logic               last;
  } token_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [7:0]         char_code_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         token_kind_o;
  logic [TOKEN_W-1:0] token_start_o;
  logic [TOKEN_W-1:0] token_length_o;
  logic [TOKEN_W-1:0] error_total_o;
  logic               last_of_run_o;

  scan_state_e        scan_st   = ST_START;
  scan_state_e        prev_st   = ST_START;
  logic [POS_W-1:0]   word_pos  = '0;
  logic [POS_W-1:0]   char_pos  = '0;
  logic [TOKEN_W-1:0] err_tally = '0;

  token_t pending_tokens[$];
  int     fails      = 0;
  int     chars_sent = 0;
  int     cycles     = 0;
  bit     no_idle    = 1'b0;

  assembly_token_scanner dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .error_total_o  (error_total_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_CAP) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk_i) out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);

  // ---------------------------------------------------------------- predictor
  function automatic scan_state_e table_step(scan_state_e s, bit digit);
    case (s)
      ST_START:          return digit ? ST_IMM : ST_ID;
      ST_IMM, ST_IMMCHK: return ST_IMM;
      ST_REG, ST_ID:     return ST_ID;
      ST_NEWLINE:        return ST_START;
      ST_COMMENT:        return ST_COMMENT;
      ST_REGCHK:         return digit ? ST_REG : ST_ID;
      default:           return ST_ERROR;
    endcase
  endfunction

  function automatic void move_to(scan_state_e s);
    prev_st = scan_st;
    scan_st = s;
  endfunction

  function automatic void bump_tally();
    if (err_tally != TALLY_MAX) err_tally = err_tally + 1'b1;
  endfunction

  function automatic void scan_char(logic [7:0] c);
    token_t           found[$];
    token_kind_e      kind;
    logic [POS_W-1:0] span;
    bit               in_comment;
    bit               letter;
    bit               digit;
    if (c == CH_NUL) begin
      scan_st   = ST_START;
      prev_st   = ST_START;
      word_pos  = '0;
      char_pos  = '0;
      err_tally = '0;
      return;
    end
    in_comment = (scan_st == ST_COMMENT);
    letter     = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit      = (c >= "0" && c <= "9");
    if (c == CH_TAB || c == CH_SPACE) begin
      if (!in_comment) move_to(ST_START);
    end else if (c == CH_R) begin
      move_to(scan_st == ST_START ? ST_REGCHK : table_step(scan_st, 1'b0));
    end else if (c == CH_MINUS) begin
      if (scan_st == ST_START) move_to(ST_IMMCHK);
      else if (!in_comment) move_to(ST_ERROR);
    end else if (c == CH_COLON) begin
      if (scan_st == ST_ID) move_to(ST_LABEL);
      else if (!in_comment) move_to(ST_ERROR);
    end else if (c == CH_NL) begin
      move_to(ST_NEWLINE);
    end else if (c == CH_HASH) begin
      move_to(ST_COMMENT);
    end else if (letter || digit) begin
      move_to(table_step(scan_st, digit));
    end else if (!in_comment) begin
      move_to(ST_ERROR);
      bump_tally();
    end

    if (scan_st == ST_START || scan_st == ST_NEWLINE) begin
      if (prev_st != ST_START && prev_st != ST_NEWLINE && prev_st != ST_COMMENT) begin
        span = char_pos - word_pos;
        case (prev_st)
          ST_REG:           kind = KIND_REG;
          ST_IMM:           kind = KIND_IMM;
          ST_ID, ST_REGCHK: kind = KIND_ID;
          ST_LABEL: begin
            kind = KIND_LABEL;
            span = span - 1'b1;
          end
          default: begin
            kind = KIND_ERR;
            bump_tally();
          end
        endcase
        found.push_back('{kind: kind, first: word_pos, span: span, tally: '0, last: 1'b0});
      end
      if (scan_st == ST_NEWLINE)
        found.push_back('{kind: KIND_NL, first: char_pos, span: TOKEN_W'(1), tally: '0,
                          last: 1'b0});
      word_pos = char_pos + 1'b1;
      move_to(ST_START);
    end else if (prev_st == ST_START) begin
      word_pos = char_pos;
    end
    char_pos = char_pos + 1'b1;

    foreach (found[i]) begin
      found[i].tally = err_tally;
      found[i].last  = (i == found.size() - 1);
      pending_tokens.push_back(found[i]);
    end
  endfunction

  // ------------------------------------------------------------------ checker
  function automatic void check_field(string name, logic [TOKEN_W-1:0] want,
                                      logic [TOKEN_W-1:0] got);
    if (got !== want) begin
      $error("%s expected %0d got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(negedge clk_i) begin
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_tokens.size() == 0) begin
        $error("token with nothing pending: kind %0d start %0d", token_kind_o, token_start_o);
        fails++;
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", TOKEN_W'(want.kind), TOKEN_W'(token_kind_o));
        check_field("token_start", want.first, token_start_o);
        check_field("token_length", want.span, token_length_o);
        check_field("error_total", want.tally, error_total_o);
        check_field("last_of_run", TOKEN_W'(want.last), TOKEN_W'(last_of_run_o));
      end
    end
  end

  // ----------------------------------------------------------------- stimulus
  task automatic send_char(logic [7:0] c);
    bit taken;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    scan_char(c);
    chars_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_char(s[i]);
  endtask

  // hold the sender until every pending token has come back
  task automatic drain_tokens();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_tokens.size() != 0);
  endtask

  function automatic logic [7:0] rand_letter();
    return $urandom_range(1) ? 8'(8'h61 + $urandom_range(25)) : 8'(8'h41 + $urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_odd_char();
    case ($urandom_range(4))
      0:       return CH_MINUS;
      1:       return CH_COLON;
      2:       return CH_R;
      3:       return rand_letter();
      default: return rand_digit();
    endcase
  endfunction

  task automatic send_word();
    case ($urandom_range(9))
      0, 1: begin
        send_char(CH_R);
        repeat ($urandom_range(1, 3)) send_char(rand_digit());
      end
      2: repeat ($urandom_range(1, 4)) send_char(rand_digit());
      3: begin
        send_char(CH_MINUS);
        repeat ($urandom_range(1, 3)) send_char($urandom_range(1) ? rand_digit() : rand_letter());
      end
      4, 5, 6: begin
        send_char(rand_letter());
        repeat ($urandom_range(0, 5)) send_char($urandom_range(2) ? rand_letter() : rand_digit());
        if ($urandom_range(2) == 0) send_char(CH_COLON);
      end
      7: begin
        send_char(CH_HASH);
        repeat ($urandom_range(0, 6)) send_char(8'($urandom_range(1, 255)));
      end
      8: repeat ($urandom_range(1, 4)) send_char(rand_odd_char());
      default: repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(1, 255)));
    endcase
  endtask

  // -------------------------------------------------------------------- tests
  task automatic test_directed_tokens();
    send_text("r5 r -x -\tb: 7#-: r");
    send_char(8'h80);
    send_char(CH_NL);
    send_char(8'hFF);
    send_char(CH_MINUS);
    send_char(CH_NL);
    send_char("q");
    send_char(CH_NUL);
  endtask

  // one long bad word: an error per character and one more for the word
  task automatic test_long_bad_word();
    drain_tokens();
    send_char(CH_NUL);
    repeat (120) send_char(8'($urandom_range(128, 255)));
    send_char(CH_SPACE);
    send_text("r7 x\n");
    send_char(CH_NUL);
  endtask

  task automatic test_random_text();
    int base;
    int words;
    base  = chars_sent;
    words = 0;
    while (chars_sent - base < 1000) begin
      no_idle = (chars_sent - base >= 400) && (chars_sent - base < 700);
      send_word();
      case ($urandom_range(7))
        0, 1:    send_char(CH_NL);
        2:       send_char(CH_TAB);
        default: repeat ($urandom_range(1, 2)) send_char(CH_SPACE);
      endcase
      if ($urandom_range(59) == 0) send_char(CH_NUL);
      words++;
      if (words % 50 == 0) drain_tokens();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_tokens();
    test_long_bad_word();
    test_random_text();
    drain_tokens();
    repeat (8) @(posedge clk_i);
    if (fails == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
hdl/ats_pkg.sv
hdl/ats_front.sv
hdl/ats_queue.sv
hdl/ats_back.sv
hdl/assembly_token_scanner.sv
hdl/ats_checker.sv
tb/sv/tb_assembly_token_scanner.sv
